@@ rtl/core/mact_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the control-store contents for the moving-average
// crossover trader. Used by every module under rtl/core; depends on nothing.
package mact_pkg;

  // Sizes
  localparam int MAX_WINDOW = 64;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 7;
  localparam int SEEN_W     = RING_AW + 1;
  localparam int PRICE_W    = 32;
  localparam int TAG_W      = 32;
  localparam int MONEY_W    = 48;
  localparam int SUM_W      = PRICE_W + RING_AW;
  localparam int CMP_W      = SUM_W + WIN_W;
  localparam int FRAC_SH    = 24;
  localparam int HALF_W     = MONEY_W - FRAC_SH;
  localparam int PROD_W     = HALF_W + PRICE_W;
  localparam int SATIN_W    = PROD_W + 1;
  localparam int DIV_STEPS  = MONEY_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = MONEY_W;

  // Reset values of the configuration and the portfolio
  localparam logic [WIN_W-1:0]   SHORT_RESET = 7'd5;
  localparam logic [WIN_W-1:0]   LONG_RESET  = 7'd20;
  localparam logic [MONEY_W-1:0] CASH_RESET  = 48'd655360000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CASH  = 2'd2;

  // Input item kinds
  localparam logic OPC_SAMPLE  = 1'b0;
  localparam logic OPC_RESTART = 1'b1;

  // Result actions
  localparam logic [1:0] ACT_WARM = 2'd0;
  localparam logic [1:0] ACT_HOLD = 2'd1;
  localparam logic [1:0] ACT_BUY  = 2'd2;
  localparam logic [1:0] ACT_SELL = 2'd3;

  // Datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 5'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 5'd2;
  localparam logic [OP_W-1:0] OP_SETUP   = 5'd3;
  localparam logic [OP_W-1:0] OP_SUM     = 5'd4;
  localparam logic [OP_W-1:0] OP_MULL    = 5'd5;
  localparam logic [OP_W-1:0] OP_MULR    = 5'd6;
  localparam logic [OP_W-1:0] OP_HOLD    = 5'd7;
  localparam logic [OP_W-1:0] OP_MLO     = 5'd8;
  localparam logic [OP_W-1:0] OP_MHI     = 5'd9;
  localparam logic [OP_W-1:0] OP_PSUM    = 5'd10;
  localparam logic [OP_W-1:0] OP_SELL    = 5'd11;
  localparam logic [OP_W-1:0] OP_DIVINIT = 5'd12;
  localparam logic [OP_W-1:0] OP_DIVSTEP = 5'd13;
  localparam logic [OP_W-1:0] OP_BUY     = 5'd14;
  localparam logic [OP_W-1:0] OP_EMIT    = 5'd15;
  localparam logic [OP_W-1:0] OP_RESTART = 5'd16;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEXT     = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS   = 4'd1;
  localparam logic [COND_W-1:0] C_NOACC    = 4'd2;
  localparam logic [COND_W-1:0] C_RESTART  = 4'd3;
  localparam logic [COND_W-1:0] C_LOOP     = 4'd4;
  localparam logic [COND_W-1:0] C_NOTREADY = 4'd5;
  localparam logic [COND_W-1:0] C_BUY      = 4'd6;
  localparam logic [COND_W-1:0] C_NOSELL   = 4'd7;
  localparam logic [COND_W-1:0] C_DIVSAT   = 4'd8;
  localparam logic [COND_W-1:0] C_DIVMORE  = 4'd9;
  localparam logic [COND_W-1:0] C_OUTBUSY  = 4'd10;

  // Control-store addresses
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] PC_DECODE  = 5'd1;
  localparam logic [PC_W-1:0] PC_WRITE   = 5'd2;
  localparam logic [PC_W-1:0] PC_SETUP   = 5'd3;
  localparam logic [PC_W-1:0] PC_SUM     = 5'd4;
  localparam logic [PC_W-1:0] PC_DRAIN   = 5'd5;
  localparam logic [PC_W-1:0] PC_MULL    = 5'd6;
  localparam logic [PC_W-1:0] PC_MULR    = 5'd7;
  localparam logic [PC_W-1:0] PC_HOLD    = 5'd8;
  localparam logic [PC_W-1:0] PC_SELLCHK = 5'd9;
  localparam logic [PC_W-1:0] PC_S_MLO   = 5'd10;
  localparam logic [PC_W-1:0] PC_S_MHI   = 5'd11;
  localparam logic [PC_W-1:0] PC_S_PSUM  = 5'd12;
  localparam logic [PC_W-1:0] PC_SELL    = 5'd13;
  localparam logic [PC_W-1:0] PC_DIVINIT = 5'd14;
  localparam logic [PC_W-1:0] PC_DIVCHK  = 5'd15;
  localparam logic [PC_W-1:0] PC_DIVSTEP = 5'd16;
  localparam logic [PC_W-1:0] PC_BUY     = 5'd17;
  localparam logic [PC_W-1:0] PC_V_MLO   = 5'd18;
  localparam logic [PC_W-1:0] PC_V_MHI   = 5'd19;
  localparam logic [PC_W-1:0] PC_V_PSUM  = 5'd20;
  localparam logic [PC_W-1:0] PC_EMIT    = 5'd21;
  localparam logic [PC_W-1:0] PC_RETURN  = 5'd22;
  localparam logic [PC_W-1:0] PC_RESTART = 5'd23;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic              in_rdy;
  } ucode_t;

  typedef struct packed {
    logic no_input;
    logic restart;
    logic loop_more;
    logic not_ready;
    logic buy;
    logic sell;
    logic div_sat;
    logic div_more;
    logic out_busy;
  } status_t;

  // Control store: one control word per step.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{OP_NOP, C_ALWAYS, PC_IDLE, 1'b0};
    unique case (pc)
      PC_IDLE:    w = '{OP_ACCEPT,  C_NOACC,    PC_IDLE,    1'b1};
      PC_DECODE:  w = '{OP_NOP,     C_RESTART,  PC_RESTART, 1'b0};
      PC_WRITE:   w = '{OP_WRITE,   C_NEXT,     PC_IDLE,    1'b0};
      PC_SETUP:   w = '{OP_SETUP,   C_NEXT,     PC_IDLE,    1'b0};
      PC_SUM:     w = '{OP_SUM,     C_LOOP,     PC_SUM,     1'b0};
      PC_DRAIN:   w = '{OP_NOP,     C_NEXT,     PC_IDLE,    1'b0};
      PC_MULL:    w = '{OP_MULL,    C_NEXT,     PC_IDLE,    1'b0};
      PC_MULR:    w = '{OP_MULR,    C_NOTREADY, PC_V_MLO,   1'b0};
      PC_HOLD:    w = '{OP_HOLD,    C_BUY,      PC_DIVINIT, 1'b0};
      PC_SELLCHK: w = '{OP_NOP,     C_NOSELL,   PC_V_MLO,   1'b0};
      PC_S_MLO:   w = '{OP_MLO,     C_NEXT,     PC_IDLE,    1'b0};
      PC_S_MHI:   w = '{OP_MHI,     C_NEXT,     PC_IDLE,    1'b0};
      PC_S_PSUM:  w = '{OP_PSUM,    C_NEXT,     PC_IDLE,    1'b0};
      PC_SELL:    w = '{OP_SELL,    C_ALWAYS,   PC_V_MLO,   1'b0};
      PC_DIVINIT: w = '{OP_DIVINIT, C_NEXT,     PC_IDLE,    1'b0};
      PC_DIVCHK:  w = '{OP_NOP,     C_DIVSAT,   PC_BUY,     1'b0};
      PC_DIVSTEP: w = '{OP_DIVSTEP, C_DIVMORE,  PC_DIVSTEP, 1'b0};
      PC_BUY:     w = '{OP_BUY,     C_NEXT,     PC_IDLE,    1'b0};
      PC_V_MLO:   w = '{OP_MLO,     C_NEXT,     PC_IDLE,    1'b0};
      PC_V_MHI:   w = '{OP_MHI,     C_NEXT,     PC_IDLE,    1'b0};
      PC_V_PSUM:  w = '{OP_PSUM,    C_NEXT,     PC_IDLE,    1'b0};
      PC_EMIT:    w = '{OP_EMIT,    C_OUTBUSY,  PC_EMIT,    1'b0};
      PC_RETURN:  w = '{OP_NOP,     C_ALWAYS,   PC_IDLE,    1'b0};
      PC_RESTART: w = '{OP_RESTART, C_ALWAYS,   PC_V_MLO,   1'b0};
      default:    w = '{OP_NOP,     C_ALWAYS,   PC_IDLE,    1'b0};
    endcase
    return w;
  endfunction

  // A window length of zero acts as one, anything above the ring depth as the depth.
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
    return (w == '0) ? WIN_W'(1) :
           ((w > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : w);
  endfunction

  function automatic logic [MONEY_W-1:0] sat_money(input logic [SATIN_W-1:0] v);
    return (v[SATIN_W-1:MONEY_W] != '0) ? '1 : v[MONEY_W-1:0];
  endfunction

endpackage

@@ rtl/core/ma_crossover_trade_signal.sv @@
`timescale 1ns / 1ps
// Dual moving-average crossover trader. With n = max(short, long) windows capped by the
// samples seen, each sample reads n prices in the ring read loop (one price a cycle), and
// a buy that does not saturate runs the 48-step divider; a restart skips both. The next
// item is accepted only after the result is loaded, and loading waits while the previous
// result is held and not taken. Synchronous reset clears the sequencer and history, loads
// cash 10000.0 and the default windows; the ring is not cleared.
module ma_crossover_trade_signal (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,  // close_price, date_tag
  input  logic [0:0]                        s_tuser,  // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [111:0]                      m_tdata,  // trade_price, out_date_tag,
                                                      // portfolio_value
  output logic [1:0]                        m_tuser,  // action
  input  logic                              cfg_we,
  input  logic [mact_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mact_pkg::CFG_W-1:0]        cfg_data
);

  logic [mact_pkg::WIN_W-1:0]   short_len;
  logic [mact_pkg::WIN_W-1:0]   long_len;
  logic [mact_pkg::MONEY_W-1:0] initial_cash;
  mact_pkg::ucode_t             ctrl;
  mact_pkg::status_t            status;
  logic [1:0]                   out_action;
  logic [mact_pkg::PRICE_W-1:0] out_price;
  logic [mact_pkg::TAG_W-1:0]   out_tag;
  logic [mact_pkg::MONEY_W-1:0] out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_len    <= mact_pkg::SHORT_RESET;
      long_len     <= mact_pkg::LONG_RESET;
      initial_cash <= mact_pkg::CASH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mact_pkg::CFG_SHORT: short_len    <= cfg_data[mact_pkg::WIN_W-1:0];
        mact_pkg::CFG_LONG:  long_len     <= cfg_data[mact_pkg::WIN_W-1:0];
        mact_pkg::CFG_CASH:  initial_cash <= cfg_data[mact_pkg::MONEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s_tready = ctrl.in_rdy;

  mact_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mact_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .in_valid     (s_tvalid),
    .in_opcode    (s_tuser[0]),
    .in_price     (s_tdata[31:0]),
    .in_tag       (s_tdata[63:32]),
    .short_len    (short_len),
    .long_len     (long_len),
    .initial_cash (initial_cash),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_action   (out_action),
    .out_price    (out_price),
    .out_tag      (out_tag),
    .out_value    (out_value)
  );

  assign m_tdata = {out_value, out_tag, out_price};
  assign m_tuser = out_action;

endmodule

@@ rtl/core/mact_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: floor(cash * 2^24 / price), one quotient bit a cycle
// while step is high. Depends on mact_pkg for widths.
module mact_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              step,
  input  logic [mact_pkg::MONEY_W-1:0]      cash,
  input  logic [mact_pkg::PRICE_W-1:0]      price,
  output logic [mact_pkg::MONEY_W-1:0]      quot,
  output logic                              sat,
  output logic                              more
);

  logic [mact_pkg::PRICE_W-1:0] rem;
  logic [mact_pkg::FRAC_SH-1:0] dvd;
  logic [mact_pkg::MONEY_W-1:0] q;
  logic [mact_pkg::DIV_CW-1:0]  cnt;
  logic                         sat_r;
  logic [mact_pkg::PRICE_W:0]   trial;
  logic [mact_pkg::PRICE_W:0]   diff;
  logic                         ge;

  // The quotient overflows 48 bits exactly when cash >= price * 2^24; this also
  // covers a zero price. Otherwise the top 24 quotient bits are zero and the
  // partial remainder starts as the upper cash bits.
  assign trial = {rem, dvd[mact_pkg::FRAC_SH-1]};
  assign diff  = trial - {1'b0, price};
  assign ge    = (trial >= {1'b0, price});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      sat_r <= 1'b0;
    end else if (start) begin
      cnt   <= '0;
      sat_r <= ({8'd0, cash} >= {price, {mact_pkg::FRAC_SH{1'b0}}});
    end else if (step) begin
      cnt <= cnt + mact_pkg::DIV_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= mact_pkg::PRICE_W'(cash[mact_pkg::MONEY_W-1:mact_pkg::FRAC_SH]);
      dvd <= cash[mact_pkg::FRAC_SH-1:0];
      q   <= '0;
    end else if (step) begin
      rem <= ge ? diff[mact_pkg::PRICE_W-1:0] : trial[mact_pkg::PRICE_W-1:0];
      dvd <= {dvd[mact_pkg::FRAC_SH-2:0], 1'b0};
      q   <= {q[mact_pkg::MONEY_W-2:0], ge};
    end
  end

  assign quot = q;
  assign sat  = sat_r;
  assign more = (cnt != mact_pkg::DIV_CW'(mact_pkg::DIV_STEPS - 1));

endmodule

@@ rtl/core/mact_seq.sv @@
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on mact_pkg for the control word, status and the control store.
module mact_seq (
  input  logic              clk,
  input  logic              rst,
  input  mact_pkg::status_t status,
  output mact_pkg::ucode_t  ctrl
);

  logic [mact_pkg::PC_W-1:0] pc;
  logic [mact_pkg::PC_W-1:0] pc_next;
  logic                      take;

  assign ctrl = mact_pkg::ucode_rom(pc);

  always_comb begin
    unique case (ctrl.cond)
      mact_pkg::C_NEXT:     take = 1'b0;
      mact_pkg::C_ALWAYS:   take = 1'b1;
      mact_pkg::C_NOACC:    take = status.no_input;
      mact_pkg::C_RESTART:  take = status.restart;
      mact_pkg::C_LOOP:     take = status.loop_more;
      mact_pkg::C_NOTREADY: take = status.not_ready;
      mact_pkg::C_BUY:      take = status.buy;
      mact_pkg::C_NOSELL:   take = !status.sell;
      mact_pkg::C_DIVSAT:   take = status.div_sat;
      mact_pkg::C_DIVMORE:  take = status.div_more;
      mact_pkg::C_OUTBUSY:  take = status.out_busy;
      default:              take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + mact_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mact_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/core/mact_dp.sv @@
`timescale 1ns / 1ps
// Datapath: price ring memory, window sums, comparison and share multipliers,
// portfolio registers and the result register. Depends on mact_pkg and mact_div.
module mact_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mact_pkg::ucode_t                    ctrl,
  output mact_pkg::status_t                   status,
  input  logic                                in_valid,
  input  logic                                in_opcode,
  input  logic [mact_pkg::PRICE_W-1:0]        in_price,
  input  logic [mact_pkg::TAG_W-1:0]          in_tag,
  input  logic [mact_pkg::WIN_W-1:0]          short_len,
  input  logic [mact_pkg::WIN_W-1:0]          long_len,
  input  logic [mact_pkg::MONEY_W-1:0]        initial_cash,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_action,
  output logic [mact_pkg::PRICE_W-1:0]        out_price,
  output logic [mact_pkg::TAG_W-1:0]          out_tag,
  output logic [mact_pkg::MONEY_W-1:0]        out_value
);

  logic [mact_pkg::PRICE_W-1:0] ring [mact_pkg::MAX_WINDOW];

  logic                         opc;
  logic [mact_pkg::PRICE_W-1:0] price;
  logic [mact_pkg::TAG_W-1:0]   tag;
  logic [mact_pkg::RING_AW-1:0] ptr;
  logic [mact_pkg::SEEN_W-1:0]  seen;
  logic [mact_pkg::SEEN_W-1:0]  ns;
  logic [mact_pkg::SEEN_W-1:0]  nl;
  logic [mact_pkg::SEEN_W-1:0]  nmax;
  logic                         ready;
  logic [mact_pkg::SEEN_W-1:0]  cnt;
  logic [mact_pkg::PRICE_W-1:0] rd_data;
  logic                         acc_v;
  logic                         acc_s;
  logic                         acc_l;
  logic [mact_pkg::SUM_W-1:0]   short_sum;
  logic [mact_pkg::SUM_W-1:0]   long_sum;
  logic [mact_pkg::CMP_W-1:0]   lhs;
  logic [mact_pkg::CMP_W-1:0]   rhs;
  logic [mact_pkg::PROD_W-1:0]  plo;
  logic [mact_pkg::PROD_W-1:0]  phi;
  logic [mact_pkg::MONEY_W-1:0] psat;
  logic [mact_pkg::MONEY_W-1:0] cash;
  logic [mact_pkg::MONEY_W-1:0] shares;
  logic [1:0]                   action;

  logic [mact_pkg::WIN_W-1:0]   sw_eff;
  logic [mact_pkg::WIN_W-1:0]   lw_eff;
  logic [mact_pkg::SEEN_W-1:0]  ns_c;
  logic [mact_pkg::SEEN_W-1:0]  nl_c;
  logic [mact_pkg::RING_AW-1:0] rd_addr;
  logic                         out_busy;
  logic                         emit;
  logic [mact_pkg::MONEY_W-1:0] div_q;
  logic                         div_sat;
  logic                         div_more;

  assign sw_eff   = mact_pkg::eff_window(short_len);
  assign lw_eff   = mact_pkg::eff_window(long_len);
  assign ns_c     = (sw_eff < seen) ? sw_eff : seen;
  assign nl_c     = (lw_eff < seen) ? lw_eff : seen;
  // Entry k back from the newest price; the pointer already points past it.
  assign rd_addr  = ptr - mact_pkg::RING_AW'(1) - cnt[mact_pkg::RING_AW-1:0];
  assign out_busy = out_valid && !out_ready;
  assign emit     = (ctrl.op == mact_pkg::OP_EMIT) && !out_busy;

  mact_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctrl.op == mact_pkg::OP_DIVINIT),
    .step  (ctrl.op == mact_pkg::OP_DIVSTEP),
    .cash  (cash),
    .price (price),
    .quot  (div_q),
    .sat   (div_sat),
    .more  (div_more)
  );

  always_comb begin
    status.no_input  = !in_valid;
    status.restart   = (opc == mact_pkg::OPC_RESTART);
    status.loop_more = ((cnt + mact_pkg::SEEN_W'(1)) < nmax);
    status.not_ready = !ready;
    status.buy       = (lhs > rhs) && (shares == '0);
    status.sell      = (lhs < rhs) && (shares != '0);
    status.div_sat   = div_sat;
    status.div_more  = div_more;
    status.out_busy  = out_busy;
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.op == mact_pkg::OP_WRITE) begin
      ring[ptr] <= price;
    end
    if (ctrl.op == mact_pkg::OP_SUM) begin
      rd_data <= ring[rd_addr];
    end
  end

  // Item latch and window bookkeeping
  always_ff @(posedge clk) begin
    if ((ctrl.op == mact_pkg::OP_ACCEPT) && in_valid) begin
      opc   <= in_opcode;
      price <= in_price;
      tag   <= in_tag;
    end
    if (ctrl.op == mact_pkg::OP_SETUP) begin
      ns    <= ns_c;
      nl    <= nl_c;
      nmax  <= (ns_c > nl_c) ? ns_c : nl_c;
      ready <= (seen >= sw_eff) && (seen >= lw_eff);
    end
    acc_s <= (cnt < ns);
    acc_l <= (cnt < nl);
    if (ctrl.op == mact_pkg::OP_MULL) begin
      lhs <= mact_pkg::CMP_W'(short_sum) * mact_pkg::CMP_W'(lw_eff);
    end
    if (ctrl.op == mact_pkg::OP_MULR) begin
      rhs <= mact_pkg::CMP_W'(long_sum) * mact_pkg::CMP_W'(sw_eff);
    end
    if (ctrl.op == mact_pkg::OP_MLO) begin
      plo <= mact_pkg::PROD_W'(shares[mact_pkg::HALF_W-1:0]) * mact_pkg::PROD_W'(price);
    end
    if (ctrl.op == mact_pkg::OP_MHI) begin
      phi <= mact_pkg::PROD_W'(shares[mact_pkg::MONEY_W-1:mact_pkg::FRAC_SH])
             * mact_pkg::PROD_W'(price);
    end
    if (ctrl.op == mact_pkg::OP_PSUM) begin
      psat <= mact_pkg::sat_money(mact_pkg::SATIN_W'(phi)
              + mact_pkg::SATIN_W'(plo[mact_pkg::PROD_W-1:mact_pkg::FRAC_SH]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      seen      <= '0;
      cnt       <= '0;
      acc_v     <= 1'b0;
      short_sum <= '0;
      long_sum  <= '0;
    end else begin
      acc_v <= (ctrl.op == mact_pkg::OP_SUM);
      if (ctrl.op == mact_pkg::OP_WRITE) begin
        ptr  <= ptr + mact_pkg::RING_AW'(1);
        seen <= (seen == mact_pkg::SEEN_W'(mact_pkg::MAX_WINDOW)) ?
                seen : seen + mact_pkg::SEEN_W'(1);
        cnt  <= '0;
      end else if (ctrl.op == mact_pkg::OP_RESTART) begin
        ptr  <= '0;
        seen <= '0;
      end else if (ctrl.op == mact_pkg::OP_SUM) begin
        cnt <= cnt + mact_pkg::SEEN_W'(1);
      end
      // Sums are rebuilt for every sample; a read issued in the loop lands here
      // in the cycle after it.
      if ((ctrl.op == mact_pkg::OP_WRITE) || (ctrl.op == mact_pkg::OP_RESTART)) begin
        short_sum <= '0;
        long_sum  <= '0;
      end else if (acc_v) begin
        if (acc_s) begin
          short_sum <= short_sum + mact_pkg::SUM_W'(rd_data);
        end
        if (acc_l) begin
          long_sum <= long_sum + mact_pkg::SUM_W'(rd_data);
        end
      end
    end
  end

  // Portfolio
  always_ff @(posedge clk) begin
    if (rst) begin
      cash   <= mact_pkg::CASH_RESET;
      shares <= '0;
      action <= mact_pkg::ACT_WARM;
    end else begin
      unique case (ctrl.op)
        mact_pkg::OP_WRITE:   action <= mact_pkg::ACT_WARM;
        mact_pkg::OP_HOLD:    action <= mact_pkg::ACT_HOLD;
        mact_pkg::OP_DIVINIT: action <= mact_pkg::ACT_BUY;
        mact_pkg::OP_BUY: begin
          shares <= div_sat ? '1 : div_q;
          cash   <= '0;
        end
        mact_pkg::OP_SELL: begin
          cash   <= psat;
          shares <= '0;
          action <= mact_pkg::ACT_SELL;
        end
        mact_pkg::OP_RESTART: begin
          cash   <= initial_cash;
          shares <= '0;
          action <= mact_pkg::ACT_WARM;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register; it holds a finished transaction until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action <= action;
      out_price  <= price;
      out_tag    <= tag;
      out_value  <= mact_pkg::sat_money(mact_pkg::SATIN_W'(cash) + mact_pkg::SATIN_W'(psat));
    end
  end

  // The portfolio is either all cash or all shares.
  a_cash_or_shares: assert property (@(posedge clk) disable iff (rst)
    (cash == '0) || (shares == '0))
    else $error("cash and shares both nonzero");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == mact_pkg::OP_SUM) |-> (cnt < nmax))
    else $error("sum loop ran past the window");

  a_seen_cap: assert property (@(posedge clk) disable iff (rst)
    seen <= mact_pkg::SEEN_W'(mact_pkg::MAX_WINDOW))
    else $error("sample count above ring depth");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == mact_pkg::OP_EMIT))
    else $error("result appeared outside the emit step");

endmodule

@@ bench/ma_crossover_trade_signal_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the moving-average crossover trader: a directed table,
// then random price runs under random idling. Depends on mact_pkg and the top module.
module ma_crossover_trade_signal_tb;
  import mact_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int SETTLE       = 200;

  typedef struct packed {
    logic [1:0]         action;
    logic [PRICE_W-1:0] price;
    logic [TAG_W-1:0]   tag;
    logic [MONEY_W-1:0] value;
  } trade_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECKED, ROW_WRITE, ROW_DONE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  opcode;
    logic [PRICE_W-1:0]    price;
    logic [TAG_W-1:0]      tag;
    logic [1:0]            action;
    logic [MONEY_W-1:0]    value;
    logic [CFG_IDX_W-1:0]  reg_index;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [63:0]          s_tdata = '0;   // close_price, date_tag
  logic [0:0]           s_tuser = '0;   // opcode
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [111:0]         m_tdata;        // trade_price, out_date_tag, portfolio_value
  logic [1:0]           m_tuser;        // action
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  ma_crossover_trade_signal uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the trader's configuration and portfolio.
  logic [WIN_W-1:0]   cfg_short_len  = SHORT_RESET;
  logic [WIN_W-1:0]   cfg_long_len   = LONG_RESET;
  logic [MONEY_W-1:0] cfg_start_cash = CASH_RESET;
  logic [PRICE_W-1:0] price_hist [0:MAX_WINDOW-1];
  logic [RING_AW-1:0] hist_wr      = '0;
  logic [SEEN_W-1:0]  hist_count   = '0;
  logic [MONEY_W-1:0] held_cash    = CASH_RESET;
  logic [MONEY_W-1:0] held_shares  = '0;

  trade_result_t pending_trades [$];
  trade_result_t want;
  bit            failed = 1'b0;
  bit            quiet = 1'b0;
  int            stall_cnt = 0;
  int            cycles = 0;

  function automatic logic [WIN_W-1:0] clip_window(input logic [WIN_W-1:0] w);
    if (w == '0) return WIN_W'(1);
    if (w > WIN_W'(MAX_WINDOW)) return WIN_W'(MAX_WINDOW);
    return w;
  endfunction

  function automatic logic [63:0] recent_total(input logic [WIN_W-1:0] n);
    logic [63:0]        acc;
    logic [RING_AW-1:0] idx;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      idx = hist_wr - RING_AW'(k + 1);
      acc = acc + 64'(price_hist[idx]);
    end
    return acc;
  endfunction

  // floor(shares * price / 2^24), clipped to 48 bits
  function automatic logic [MONEY_W-1:0] position_worth(input logic [MONEY_W-1:0] sh,
                                                        input logic [PRICE_W-1:0] price);
    logic [79:0] p;
    p = (80'(sh) * 80'(price)) >> FRAC_SH;
    return (p[79:MONEY_W] != '0) ? '1 : p[MONEY_W-1:0];
  endfunction

  // floor(cash * 2^24 / price), clipped to 48 bits; a zero price clips too
  function automatic logic [MONEY_W-1:0] shares_for_cash(input logic [MONEY_W-1:0] cash,
                                                         input logic [PRICE_W-1:0] price);
    logic [79:0] q;
    if (price == '0) return '1;
    q = {8'd0, cash, 24'd0} / 80'(price);
    return (q[79:MONEY_W] != '0) ? '1 : q[MONEY_W-1:0];
  endfunction

  function automatic trade_result_t predict_trade(input logic opcode,
                                                  input logic [PRICE_W-1:0] price,
                                                  input logic [TAG_W-1:0] tag);
    trade_result_t r;
    logic [WIN_W-1:0] sw, lw, ns, nl;
    logic [63:0]      lhs, rhs;
    logic [MONEY_W:0] total;
    r.action = ACT_WARM;
    if (opcode == OPC_RESTART) begin
      hist_wr     = '0;
      hist_count  = '0;
      held_cash   = cfg_start_cash;
      held_shares = '0;
    end else begin
      sw = clip_window(cfg_short_len);
      lw = clip_window(cfg_long_len);
      price_hist[hist_wr] = price;
      hist_wr = hist_wr + 1'b1;
      if (hist_count < SEEN_W'(MAX_WINDOW)) hist_count = hist_count + 1'b1;
      ns = (sw < hist_count) ? sw : hist_count;
      nl = (lw < hist_count) ? lw : hist_count;
      // Exact comparison of the averages by cross-multiplying with the lengths.
      lhs = recent_total(ns) * 64'(lw);
      rhs = recent_total(nl) * 64'(sw);
      if (hist_count >= sw && hist_count >= lw) begin
        r.action = ACT_HOLD;
        if (lhs > rhs && held_shares == '0) begin
          held_shares = shares_for_cash(held_cash, price);
          held_cash   = '0;
          r.action    = ACT_BUY;
        end else if (lhs < rhs && held_shares != '0) begin
          held_cash   = position_worth(held_shares, price);
          held_shares = '0;
          r.action    = ACT_SELL;
        end
      end
    end
    total   = {1'b0, held_cash} + {1'b0, position_worth(held_shares, price)};
    r.price = price;
    r.tag   = tag;
    r.value = total[MONEY_W] ? '1 : total[MONEY_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic script_row_t item_row(input logic op, input logic [31:0] price,
                                           input logic [31:0] tag);
    script_row_t r;
    r = '0;
    r.kind = ROW_ITEM; r.opcode = op; r.price = price; r.tag = tag;
    return r;
  endfunction

  function automatic script_row_t checked_row(input logic op, input logic [31:0] price,
                                              input logic [31:0] tag, input logic [1:0] act,
                                              input logic [47:0] value);
    script_row_t r;
    r = item_row(op, price, tag);
    r.kind = ROW_CHECKED; r.action = act; r.value = value;
    return r;
  endfunction

  function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [47:0] value);
    script_row_t r;
    r = '0;
    r.kind = ROW_WRITE; r.reg_index = idx; r.value = value;
    return r;
  endfunction

  // Directed table. Rows with a typed result are read straight off the rules:
  // reset state, restarts and warm-up, also at the cash extremes.
  function automatic script_row_t script_row(input int n);
    script_row_t r;
    r = '0;
    r.kind = ROW_DONE;
    case (n)
      0:  r = checked_row(OPC_SAMPLE,  32'hFFFF_FFFF, 32'h0000_0000, ACT_WARM, CASH_RESET);
      1:  r = checked_row(OPC_RESTART, 32'h0000_0000, 32'hFFFF_FFFF, ACT_WARM, CASH_RESET);
      // Tiny cash against a huge price: the buy yields no shares.
      2:  r = write_row(CFG_SHORT, 48'd1);
      3:  r = write_row(CFG_LONG,  48'd2);
      4:  r = write_row(CFG_CASH,  48'd1);
      5:  r = checked_row(OPC_RESTART, 32'h1234_5678, 32'h0000_0001, ACT_WARM, 48'd1);
      6:  r = checked_row(OPC_SAMPLE,  32'h0001_0000, 32'h0000_0002, ACT_WARM, 48'd1);
      7:  r = item_row(OPC_SAMPLE,  32'hFFFF_FFFF, 32'h0000_0003);
      8:  r = item_row(OPC_SAMPLE,  32'h0001_0000, 32'h0000_0004);
      // Maximum cash: saturated buy, saturated value, sell at zero, buy with no cash.
      9:  r = write_row(CFG_CASH, 48'hFFFF_FFFF_FFFF);
      10: r = checked_row(OPC_RESTART, 32'hA5A5_A5A5, 32'h5A5A_5A5A, ACT_WARM,
                          48'hFFFF_FFFF_FFFF);
      11: r = checked_row(OPC_SAMPLE, 32'h0001_0000, 32'h8000_0000, ACT_WARM,
                          48'hFFFF_FFFF_FFFF);
      12: r = item_row(OPC_SAMPLE, 32'h0000_0000, 32'h8000_0001);
      13: r = item_row(OPC_SAMPLE, 32'h0002_0000, 32'h8000_0002);
      14: r = item_row(OPC_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0003);
      15: r = item_row(OPC_SAMPLE, 32'h0000_0000, 32'h8000_0004);
      16: r = item_row(OPC_SAMPLE, 32'h0000_0001, 32'h8000_0005);
      // A buy at a zero price saturates the share count.
      17: r = write_row(CFG_SHORT, 48'd2);
      18: r = write_row(CFG_LONG,  48'd3);
      19: r = write_row(CFG_CASH,  48'(CASH_RESET));
      20: r = checked_row(OPC_RESTART, 32'h0000_0000, 32'h0000_0010, ACT_WARM, CASH_RESET);
      21: r = checked_row(OPC_SAMPLE,  32'h0000_0000, 32'h0000_0011, ACT_WARM, CASH_RESET);
      22: r = checked_row(OPC_SAMPLE,  32'h7FFF_0000, 32'h0000_0012, ACT_WARM, CASH_RESET);
      23: r = item_row(OPC_SAMPLE, 32'h0000_0000, 32'h0000_0013);
      // Out-of-range window lengths, changed without a restart.
      24: r = write_row(CFG_SHORT, 48'd0);
      25: r = write_row(CFG_LONG,  48'd127);
      26: r = item_row(OPC_SAMPLE, 32'h0001_0000, 32'h0000_0014);
      27: r = item_row(OPC_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0015);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [PRICE_W-1:0] price,
                           input logic [TAG_W-1:0] tag, input bit typed,
                           input logic [1:0] act, input logic [MONEY_W-1:0] value);
    int            gap;
    trade_result_t r;
    gap = pick_gap();
    cfg_we <= 1'b0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = predict_trade(op, price, tag);
    if (typed) begin
      r.action = act;
      r.value  = value;
    end
    pending_trades.insert(pending_trades.size(), r);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {tag, price};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_trades.size() != 0) @(posedge clk);
  endtask

  // Every item yields a result, so the trader is idle once the queue is empty.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [MONEY_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_SHORT: cfg_short_len  = value[WIN_W-1:0];
      CFG_LONG:  cfg_long_len   = value[WIN_W-1:0];
      CFG_CASH:  cfg_start_cash = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [WIN_W-1:0] pick_window();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return WIN_W'(1);
      2: return WIN_W'(MAX_WINDOW);
      3: return '1;
      4: return WIN_W'($urandom_range(MAX_WINDOW + 1, 127));
      5: return WIN_W'($urandom_range(13, MAX_WINDOW));
      default: return WIN_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [MONEY_W-1:0] pick_cash();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return '0;
      1: return '1;
      2: return {$urandom(), 16'(($urandom()))};
      3: return CASH_RESET;
      default: return MONEY_W'($urandom_range(1, 1000000)) << 16;
    endcase
  endfunction

  // Receiver: mostly ready, with short and occasional long stalls.
  always @(posedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt = stall_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25)
        stall_cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_trades.size() == 0) begin
        $error("result transaction with nothing expected: action %0d tag %h",
               m_tuser, m_tdata[63:32]);
        failed = 1'b1;
      end else begin
        want = pending_trades.pop_front();
        if (m_tuser !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, m_tuser);
          failed = 1'b1;
        end
        if (m_tdata[31:0] !== want.price) begin
          $error("trade_price: expected %h, got %h", want.price, m_tdata[31:0]);
          failed = 1'b1;
        end
        if (m_tdata[63:32] !== want.tag) begin
          $error("out_date_tag: expected %h, got %h", want.tag, m_tdata[63:32]);
          failed = 1'b1;
        end
        if (m_tdata[111:64] !== want.value) begin
          $error("portfolio_value: expected %h, got %h", want.value, m_tdata[111:64]);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ma_crossover_trade_signal_tb: errors");
      $finish;
    end
  end

  initial begin
    script_row_t     row;
    int              n, sent, phase_len, trend, mode;
    int unsigned     step_max;
    longint          level, move;
    logic [PRICE_W-1:0] price;

    for (int k = 0; k < MAX_WINDOW; k++) price_hist[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    n   = 0;
    row = script_row(n);
    while (row.kind != ROW_DONE) begin
      if (row.kind == ROW_WRITE)
        write_register(row.reg_index, row.value);
      else
        send_item(row.opcode, row.price, row.tag, row.kind == ROW_CHECKED,
                  row.action, row.value);
      n++;
      row = script_row(n);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 2) != 0) write_register(CFG_SHORT, MONEY_W'(pick_window()));
        if ($urandom_range(0, 2) != 0) write_register(CFG_LONG, MONEY_W'(pick_window()));
        if ($urandom_range(0, 2) != 0) write_register(CFG_CASH, pick_cash());
      end
      quiet <= ($urandom_range(0, 3) == 0);

      // Price level of the run: mostly moderate, sometimes near zero or near the top.
      mode = $urandom_range(0, 7);
      if (mode == 0) level = longint'(32'hF000_0000) + longint'($urandom_range(0, 32'h0FFF_FFFF));
      else if (mode == 1) level = longint'($urandom_range(0, 16));
      else level = longint'($urandom_range(32'h0001_0000, 32'h0100_0000));
      step_max = int'(level / 16) + 1;
      trend    = ($urandom_range(0, 1) == 0) ? 1 : -1;

      if ($urandom_range(0, 3) != 0) begin
        send_item(OPC_RESTART, $urandom(), $urandom(), 1'b0, ACT_WARM, '0);
        sent++;
      end

      phase_len = $urandom_range(20, 120);
      for (int i = 0; i < phase_len; i++) begin
        n = $urandom_range(0, 99);
        if (n < 3) begin
          send_item(OPC_RESTART, $urandom(), $urandom(), 1'b0, ACT_WARM, '0);
        end else begin
          if (n < 8) begin
            price = $urandom();
          end else begin
            // Trending walk with noise; trend flips make the averages cross.
            if ($urandom_range(0, 9) == 0) trend = -trend;
            move  = longint'($urandom_range(0, step_max));
            level = level + trend * move + longint'($urandom_range(0, step_max))
                    - longint'(step_max / 2);
            if (level < 0) level = 0;
            if (level > longint'(32'hFFFF_FFFF)) level = longint'(32'hFFFF_FFFF);
            price = level[31:0];
          end
          send_item(OPC_SAMPLE, price, $urandom(), 1'b0, ACT_WARM, '0);
        end
        sent++;
      end
    end

    wait_for_results();
    cfg_we <= 1'b0;
    repeat (SETTLE) @(posedge clk);
    if (pending_trades.size() != 0) begin
      $error("%0d expected results never arrived", pending_trades.size());
      failed = 1'b1;
    end
    if (!failed)
      $display("ma_crossover_trade_signal_tb: clean");
    else
      $display("ma_crossover_trade_signal_tb: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mact_pkg.sv
rtl/core/mact_div.sv
rtl/core/mact_seq.sv
rtl/core/mact_dp.sv
rtl/core/ma_crossover_trade_signal.sv
bench/ma_crossover_trade_signal_tb.sv
